### sv/ptt_pkg.sv
// Package for the periodic task timer table: command, mode and register codes,
// request and result payload types, and the control bundles between modules.
// No dependencies.
`default_nettype none
package ptt_pkg;

  localparam int NUM_TASKS_DEF = 8;

  localparam int CMD_W   = 3;
  localparam int TIDX_W  = 3;
  localparam int CODE_W  = 16;
  localparam int DELAY_W = 32;
  localparam int IVAL_W  = 16;
  localparam int TICK_W  = 64;
  localparam int WIV_W   = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POST  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GET   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TAKE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_MODE  = 3'd5;

  localparam logic [1:0] MODE_FAST_RUN = 2'd0;
  localparam logic [1:0] MODE_SLOW_REQ = 2'd1;
  localparam logic [1:0] MODE_FAST_REQ = 2'd2;
  localparam logic [1:0] MODE_SLOW_RUN = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_START    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_INTERVAL = 1'd1;

  localparam logic [TICK_W-1:0] FAST_STEP = 64'd5;
  localparam logic [TICK_W-1:0] SLOW_STEP = 64'd1000;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [TIDX_W-1:0]  task_index;
    logic [CODE_W-1:0]  event_code;
    logic [DELAY_W-1:0] delay;
    logic [IVAL_W-1:0]  interval_value;
    logic               mode_request;
  } ptt_in_t;

  typedef struct packed {
    logic              ok;
    logic [CODE_W-1:0] event_out;
    logic              wake;
    logic              slow_period;
    logic [TICK_W-1:0] tick_now;
  } ptt_out_t;

  typedef struct packed {
    logic              load_en;
    logic              take_en;
    logic [TIDX_W-1:0] idx;
    logic [IVAL_W-1:0] ival;
  } ptt_tbl_ctrl_t;

  typedef struct packed {
    logic               post_en;
    logic               clear_en;
    logic [TIDX_W-1:0]  idx;
    logic [CODE_W-1:0]  code;
    logic [TICK_W-1:0]  start;
    logic [DELAY_W-1:0] delay;
  } ptt_mbx_ctrl_t;

endpackage
`default_nettype wire

### sv/ptt_in_if.sv
// Request channel interface: valid, ready and the request payload.
// Depends on ptt_pkg.
`default_nettype none
interface ptt_in_if import ptt_pkg::*; ();
  logic    valid;
  logic    ready;
  ptt_in_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/ptt_out_if.sv
// Result channel interface: valid, ready and the result payload.
// Depends on ptt_pkg.
`default_nettype none
interface ptt_out_if import ptt_pkg::*; ();
  logic     valid;
  logic     ready;
  ptt_out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/ptt_addsub.sv
// Shared 64-bit add/subtract unit with carry out, used for decrements,
// tick advance and all elapsed-time compares. Depends on ptt_pkg.
`default_nettype none
module ptt_addsub import ptt_pkg::*; (
  input  wire logic [TICK_W-1:0] a,
  input  wire logic [TICK_W-1:0] b,
  input  wire logic              sub,
  output logic      [TICK_W-1:0] sum,
  output logic                   carry
);
  logic [TICK_W:0] full;

  always_comb begin
    full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{TICK_W{1'b0}}, sub};
    sum   = full[TICK_W-1:0];
    carry = full[TICK_W];
  end
endmodule
`default_nettype wire

### sv/ptt_task_table.sv
// Task table: countdowns, reload intervals, present and run flags, walked one
// entry per cycle on a tick. Depends on ptt_pkg.
`default_nettype none
module ptt_task_table import ptt_pkg::*; #(
  parameter int NUM_TASKS = NUM_TASKS_DEF,
  parameter int TASK_W    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              walk_en,
  input  wire logic [TASK_W-1:0] walk_idx,
  input  wire logic [IVAL_W-1:0] dec_val,
  input  wire ptt_tbl_ctrl_t     ctrl,
  output logic      [IVAL_W-1:0] walk_cnt,
  output logic                   take_ok
);
  logic [IVAL_W-1:0] count_r  [NUM_TASKS];
  logic [IVAL_W-1:0] reload_r [NUM_TASKS];
  logic [NUM_TASKS-1:0] present_r;
  logic [NUM_TASKS-1:0] run_r;
  logic [TASK_W-1:0] tix;

  always_comb begin
    tix      = TASK_W'(ctrl.idx);
    walk_cnt = count_r[walk_idx];
    take_ok  = run_r[tix] & present_r[tix];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        count_r[i]  <= '0;
        reload_r[i] <= '0;
      end
      present_r <= '0;
      run_r     <= '0;
    end else begin
      if (walk_en) begin
        if (walk_cnt == '0) begin
          count_r[walk_idx] <= reload_r[walk_idx];
          run_r[walk_idx]   <= 1'b1;
        end else begin
          count_r[walk_idx] <= dec_val;
        end
      end
      if (ctrl.load_en) begin
        reload_r[tix]  <= ctrl.ival;
        present_r[tix] <= 1'b1;
      end
      if (ctrl.take_en) begin
        run_r[tix] <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

### sv/ptt_mailbox.sv
// Per-task one-entry event mailboxes: pending flags with reset, and event
// code, start tick and delay stores without reset. Depends on ptt_pkg.
`default_nettype none
module ptt_mailbox import ptt_pkg::*; #(
  parameter int NUM_TASKS = NUM_TASKS_DEF,
  parameter int TASK_W    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ptt_mbx_ctrl_t      ctrl,
  output logic                    pending,
  output logic      [CODE_W-1:0]  value,
  output logic      [TICK_W-1:0]  start,
  output logic      [DELAY_W-1:0] delay
);
  logic [NUM_TASKS-1:0] pend_r;
  logic [CODE_W-1:0]    value_r [NUM_TASKS];
  logic [TICK_W-1:0]    start_r [NUM_TASKS];
  logic [DELAY_W-1:0]   delay_r [NUM_TASKS];
  logic [TASK_W-1:0]    tix;

  always_comb begin
    tix     = TASK_W'(ctrl.idx);
    pending = pend_r[tix];
    value   = value_r[tix];
    start   = start_r[tix];
    delay   = delay_r[tix];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (ctrl.post_en) begin
      pend_r[tix] <= 1'b1;
    end else if (ctrl.clear_en) begin
      pend_r[tix] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.post_en) begin
      value_r[tix] <= ctrl.code;
      start_r[tix] <= ctrl.start;
      delay_r[tix] <= ctrl.delay;
    end
  end
endmodule
`default_nettype wire

### sv/periodic_task_timer_table.sv
// Periodic task timer table: a tick walks every task entry, one per cycle,
// through one shared 64-bit add/subtract unit under a small sequencer.
// A tick walks the table, then advances the tick counter and, in the slow period,
// checks the wake window; get event adds a delay compare when its mailbox holds one.
// One request at a time; ready returns in the same cycle that the result is registered.
// Synchronous active-low reset clears the task table, mailbox pending flags, counter and mode.
`default_nettype none
module periodic_task_timer_table import ptt_pkg::*; #(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ptt_in_if.sink                     in_ch,
  ptt_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);
  localparam int TASK_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_WALK  = 4'd2;
  localparam logic [3:0] S_TADD  = 4'd3;
  localparam logic [3:0] S_WAKE1 = 4'd4;
  localparam logic [3:0] S_WAKE2 = 4'd5;
  localparam logic [3:0] S_GET2  = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [3:0]          state_r, state_nxt;
  ptt_in_t             req_r, req_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic [TICK_W-1:0]   wstart_r;
  logic [WIV_W-1:0]    wiv_r;
  logic [TICK_W-1:0]   acc_r, acc_nxt;
  logic [TASK_W-1:0]   walk_r, walk_nxt;
  logic                ok_r, ok_nxt;
  logic [CODE_W-1:0]   ev_r, ev_nxt;
  logic                wake_r, wake_nxt;
  logic                out_valid_r, out_valid_nxt;
  ptt_out_t            out_r, out_nxt;

  logic [TICK_W-1:0]   alu_a, alu_b, alu_sum;
  logic                alu_sub, alu_carry;
  logic                walk_en;
  logic [IVAL_W-1:0]   walk_cnt;
  logic                take_ok;
  ptt_tbl_ctrl_t       tbl_ctrl;
  ptt_mbx_ctrl_t       mbx_ctrl;
  logic                mbx_pending;
  logic [CODE_W-1:0]   mbx_value;
  logic [TICK_W-1:0]   mbx_start;
  logic [DELAY_W-1:0]  mbx_delay;
  logic                tvalid;

  ptt_addsub u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  ptt_task_table #(.NUM_TASKS(NUM_TASKS), .TASK_W(TASK_W)) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .walk_en  (walk_en),
    .walk_idx (walk_r),
    .dec_val  (alu_sum[IVAL_W-1:0]),
    .ctrl     (tbl_ctrl),
    .walk_cnt (walk_cnt),
    .take_ok  (take_ok)
  );

  ptt_mailbox #(.NUM_TASKS(NUM_TASKS), .TASK_W(TASK_W)) u_mbx (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (mbx_ctrl),
    .pending (mbx_pending),
    .value   (mbx_value),
    .start   (mbx_start),
    .delay   (mbx_delay)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    tick_nxt      = tick_r;
    mode_nxt      = mode_r;
    acc_nxt       = acc_r;
    walk_nxt      = walk_r;
    ok_nxt        = ok_r;
    ev_nxt        = ev_r;
    wake_nxt      = wake_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    alu_a         = '0;
    alu_b         = '0;
    alu_sub       = 1'b0;
    walk_en       = 1'b0;
    tvalid        = (32'(req_r.task_index) < 32'(NUM_TASKS));

    tbl_ctrl          = '0;
    tbl_ctrl.idx      = req_r.task_index;
    tbl_ctrl.ival     = req_r.interval_value;
    mbx_ctrl          = '0;
    mbx_ctrl.idx      = req_r.task_index;
    mbx_ctrl.code     = req_r.event_code;
    mbx_ctrl.start    = tick_r;
    mbx_ctrl.delay    = req_r.delay;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          req_nxt   = in_ch.data;
          ok_nxt    = 1'b0;
          ev_nxt    = '0;
          wake_nxt  = 1'b0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (req_r.command)
          CMD_TICK: begin
            walk_nxt  = '0;
            state_nxt = S_WALK;
          end
          CMD_POST: begin
            mbx_ctrl.post_en = tvalid;
            ok_nxt           = tvalid;
          end
          CMD_GET: begin
            alu_a   = tick_r;
            alu_b   = mbx_start;
            alu_sub = 1'b1;
            acc_nxt = alu_sum;
            if (tvalid && mbx_pending) begin
              state_nxt = S_GET2;
            end
          end
          CMD_TAKE: begin
            tbl_ctrl.take_en = tvalid && take_ok;
            ok_nxt           = tvalid && take_ok;
          end
          CMD_LOAD: begin
            tbl_ctrl.load_en = tvalid;
          end
          CMD_MODE: begin
            if (req_r.mode_request) begin
              if (mode_r == MODE_FAST_RUN) begin
                mode_nxt = MODE_SLOW_REQ;
              end else if (mode_r == MODE_FAST_REQ) begin
                mode_nxt = MODE_SLOW_RUN;
              end
            end else begin
              if (mode_r == MODE_SLOW_RUN) begin
                mode_nxt = MODE_FAST_REQ;
              end else if (mode_r == MODE_SLOW_REQ) begin
                mode_nxt = MODE_FAST_RUN;
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_WALK: begin
        alu_a   = TICK_W'(walk_cnt);
        alu_b   = TICK_W'(1);
        alu_sub = 1'b1;
        walk_en = 1'b1;
        walk_nxt = walk_r + 1'b1;
        if (walk_r == TASK_W'(NUM_TASKS - 1)) begin
          state_nxt = S_TADD;
        end
      end
      S_TADD: begin
        alu_a    = tick_r;
        tick_nxt = alu_sum;
        case (mode_r)
          MODE_FAST_REQ: begin
            alu_b     = SLOW_STEP;
            mode_nxt  = MODE_FAST_RUN;
            state_nxt = S_WAKE1;
          end
          MODE_SLOW_RUN: begin
            alu_b     = SLOW_STEP;
            state_nxt = S_WAKE1;
          end
          MODE_SLOW_REQ: begin
            alu_b     = FAST_STEP;
            mode_nxt  = MODE_SLOW_RUN;
            state_nxt = S_DONE;
          end
          default: begin
            alu_b     = FAST_STEP;
            mode_nxt  = MODE_FAST_RUN;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_WAKE1: begin
        alu_a     = tick_r;
        alu_b     = wstart_r;
        alu_sub   = 1'b1;
        acc_nxt   = alu_sum;
        state_nxt = S_WAKE2;
      end
      S_WAKE2: begin
        alu_a     = TICK_W'(wiv_r);
        alu_b     = acc_r;
        alu_sub   = 1'b1;
        wake_nxt  = ~alu_carry;
        state_nxt = S_DONE;
      end
      S_GET2: begin
        alu_a   = acc_r;
        alu_b   = TICK_W'(mbx_delay);
        alu_sub = 1'b1;
        if (alu_carry) begin
          ok_nxt            = 1'b1;
          ev_nxt            = mbx_value;
          mbx_ctrl.clear_en = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt       = 1'b1;
          out_nxt.ok          = ok_r;
          out_nxt.event_out   = ev_r;
          out_nxt.wake        = wake_r;
          out_nxt.slow_period = (mode_r == MODE_SLOW_RUN) || (mode_r == MODE_FAST_REQ);
          out_nxt.tick_now    = tick_r;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      mode_r      <= MODE_FAST_RUN;
      wstart_r    <= '0;
      wiv_r       <= '0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      mode_r      <= mode_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_WAKE_START:    wstart_r <= cfg_wdata;
          CFG_WAKE_INTERVAL: wiv_r    <= cfg_wdata[WIV_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    acc_r  <= acc_nxt;
    ok_r   <= ok_nxt;
    ev_r   <= ev_nxt;
    wake_r <= wake_nxt;
    out_r  <= out_nxt;
  end
endmodule
`default_nettype wire

### sv/ptt_checker.sv
// Port-level checker for the periodic task timer table, bound to the top level.
// Depends on ptt_pkg and periodic_task_timer_table.
`default_nettype none
module ptt_checker import ptt_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_ok,
  input wire logic              out_wake,
  input wire logic [CODE_W-1:0] out_event_out,
  input wire logic [TICK_W-1:0] out_tick_now
);
  // A request occupies the sequencer, so ready drops right after acceptance.
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after a request was accepted");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tick_now) && $stable(out_ok))
    else $error("stalled result changed or dropped");

  // Wake only comes from a tick, which never reports ok.
  a_ok_wake_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_ok && out_wake))
    else $error("ok and wake raised together");

  a_event_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_out != '0) |-> out_ok)
    else $error("event code returned without ok");
endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_ok        (out_ch.data.ok),
  .out_wake      (out_ch.data.wake),
  .out_event_out (out_ch.data.event_out),
  .out_tick_now  (out_ch.data.tick_now)
);
`default_nettype wire
